### hw/rtl/sfdl_pkg.sv
`default_nettype none

package sfdl_pkg;

  localparam int DEF_RING_DEPTH  = 32768;
  localparam int DEF_SAMPLE_BITS = 24;

  localparam int DELAY_W   = 16;
  localparam int GAIN_W    = 15;
  localparam int COEF_W    = 16;
  // Multiplier coefficient operand: wide enough for a signed coefficient
  // and for an unsigned gain extended with a zero sign bit.
  localparam int OPND_W    = 17;
  localparam int FRAC_BITS = 14;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  localparam logic [DELAY_W-1:0]       DELAY_RST     = 16'd22050;
  localparam logic [GAIN_W-1:0]        PRE_GAIN_RST  = 15'd12288;
  localparam logic [GAIN_W-1:0]        FB_GAIN_RST   = 15'd16368;
  localparam logic [GAIN_W-1:0]        WET_GAIN_RST  = 15'd16384;
  localparam logic signed [COEF_W-1:0] COEF_X0_RST   = 16'sd2904;
  localparam logic signed [COEF_W-1:0] COEF_X1_RST   = 16'sd5808;
  localparam logic signed [COEF_W-1:0] COEF_Y1_RST   = -16'sd8335;
  localparam logic signed [COEF_W-1:0] COEF_Y2_RST   = 16'sd3567;

  typedef enum logic [2:0] {
    REG_DELAY_LENGTH,
    REG_PRE_GAIN,
    REG_FEEDBACK_GAIN,
    REG_WET_GAIN,
    REG_COEF_X0_X2,
    REG_COEF_X1,
    REG_COEF_Y1,
    REG_COEF_Y2
  } reg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]        pre_gain;
    logic [GAIN_W-1:0]        feedback_gain;
    logic [GAIN_W-1:0]        wet_gain;
    logic signed [COEF_W-1:0] coef_x0_x2;
    logic signed [COEF_W-1:0] coef_x1;
    logic signed [COEF_W-1:0] coef_y1;
    logic signed [COEF_W-1:0] coef_y2;
  } cfg_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // One entry per cycle of the frame schedule; STEP_OUT holds until the
  // output register is free. Left and right alternate on the shared
  // multiplier; the product is registered and accumulated one step later.
  typedef enum logic [4:0] {
    STEP_PRE_L,
    STEP_PRE_R,
    STEP_FB_L,
    STEP_FB_R,
    STEP_X1_L,
    STEP_X1_R,
    STEP_X2_L,
    STEP_X2_R,
    STEP_Y1_L,
    STEP_Y1_R,
    STEP_Y2_L,
    STEP_Y2_R,
    STEP_MIX_L,
    STEP_MIX_R,
    STEP_ACC_R,
    STEP_WET_L,
    STEP_WET_R,
    STEP_ROUND_L,
    STEP_ROUND_R,
    STEP_OUT
  } step_e;

  typedef struct packed {
    logic  load;
    logic  run;
    step_e step;
  } mac_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/sfdl_regs.sv
`default_nettype none

module sfdl_regs #(
  parameter int RING_DEPTH = sfdl_pkg::DEF_RING_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic [sfdl_pkg::APB_AW-1:0]    paddr_i,
  input  logic [sfdl_pkg::APB_DW-1:0]    pwdata_i,
  output logic [sfdl_pkg::APB_DW-1:0]    prdata_o,
  output logic                           pready_o,
  output sfdl_pkg::cfg_t                 cfg_o,
  output logic [$clog2(RING_DEPTH)-1:0]  dmod_o,
  output logic                           busy_o
);
  import sfdl_pkg::*;

  localparam int AW    = $clog2(RING_DEPTH);
  localparam int MW    = DELAY_W + AW + 1;
  localparam int CNT_W = $clog2(DELAY_W);
  localparam logic [DELAY_W-1:0] DMOD_RST = DELAY_W'(int'(DELAY_RST) % RING_DEPTH);
  localparam logic [CNT_W-1:0]   CNT_TOP  = CNT_W'(DELAY_W - 1);

  logic [DELAY_W-1:0] delay_q;
  cfg_t               cfg_q;
  logic [DELAY_W-1:0] rem_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q;
  logic               wr_en;
  reg_idx_e           idx;
  logic [MW-1:0]      shifted;

  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign idx      = reg_idx_e'(paddr_i[4:2]);
  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;
  assign dmod_o   = rem_q[AW-1:0];
  assign busy_o   = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q             <= DELAY_RST;
      cfg_q.pre_gain      <= PRE_GAIN_RST;
      cfg_q.feedback_gain <= FB_GAIN_RST;
      cfg_q.wet_gain      <= WET_GAIN_RST;
      cfg_q.coef_x0_x2    <= COEF_X0_RST;
      cfg_q.coef_x1       <= COEF_X1_RST;
      cfg_q.coef_y1       <= COEF_Y1_RST;
      cfg_q.coef_y2       <= COEF_Y2_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_DELAY_LENGTH:  delay_q             <= pwdata_i[DELAY_W-1:0];
        REG_PRE_GAIN:      cfg_q.pre_gain      <= pwdata_i[GAIN_W-1:0];
        REG_FEEDBACK_GAIN: cfg_q.feedback_gain <= pwdata_i[GAIN_W-1:0];
        REG_WET_GAIN:      cfg_q.wet_gain      <= pwdata_i[GAIN_W-1:0];
        REG_COEF_X0_X2:    cfg_q.coef_x0_x2    <= pwdata_i[COEF_W-1:0];
        REG_COEF_X1:       cfg_q.coef_x1       <= pwdata_i[COEF_W-1:0];
        REG_COEF_Y1:       cfg_q.coef_y1       <= pwdata_i[COEF_W-1:0];
        REG_COEF_Y2:       cfg_q.coef_y2       <= pwdata_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // The delay is reduced modulo the ring depth by restoring subtraction,
  // one shifted multiple of the depth per cycle, after each write to it.
  assign shifted = MW'(RING_DEPTH) << cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= DMOD_RST;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (wr_en && idx == REG_DELAY_LENGTH) begin
      rem_q  <= pwdata_i[DELAY_W-1:0];
      cnt_q  <= CNT_TOP;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      if (MW'(rem_q) >= shifted) begin
        rem_q <= rem_q - shifted[DELAY_W-1:0];
      end
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_DELAY_LENGTH:  prdata_o = APB_DW'(delay_q);
      REG_PRE_GAIN:      prdata_o = APB_DW'(cfg_q.pre_gain);
      REG_FEEDBACK_GAIN: prdata_o = APB_DW'(cfg_q.feedback_gain);
      REG_WET_GAIN:      prdata_o = APB_DW'(cfg_q.wet_gain);
      REG_COEF_X0_X2:    prdata_o = APB_DW'($unsigned(cfg_q.coef_x0_x2));
      REG_COEF_X1:       prdata_o = APB_DW'($unsigned(cfg_q.coef_x1));
      REG_COEF_Y1:       prdata_o = APB_DW'($unsigned(cfg_q.coef_y1));
      REG_COEF_Y2:       prdata_o = APB_DW'($unsigned(cfg_q.coef_y2));
      default:           prdata_o = '0;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/sfdl_ring_ram.sv
`default_nettype none

module sfdl_ring_ram #(
  parameter int DEPTH = sfdl_pkg::DEF_RING_DEPTH,
  parameter int WIDTH = 2 * sfdl_pkg::DEF_SAMPLE_BITS
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/sfdl_mac.sv
`default_nettype none

module sfdl_mac #(
  parameter int SAMPLE_BITS = sfdl_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sfdl_pkg::mac_ctl_t            ctl_i,
  input  sfdl_pkg::cfg_t                cfg_i,
  input  logic signed [SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [SAMPLE_BITS-1:0] right_in_i,
  input  logic [2*SAMPLE_BITS-1:0]      tap_raw_i,
  input  logic                          tap_ok_i,
  input  logic                          tap_eq_i,
  output logic [2*SAMPLE_BITS-1:0]      wr_data_o,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o
);
  import sfdl_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int PW    = OPND_W + SB;
  localparam int ACC_W = PW + 1;
  localparam int QW    = ACC_W - FRAC_BITS;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (FRAC_BITS - 1));
  localparam logic [SB-1:0] SMAX = {1'b0, {(SB - 1){1'b1}}};
  localparam logic [SB-1:0] SMIN = {1'b1, {(SB - 1){1'b0}}};

  function automatic logic signed [SB-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] t;
    logic [QW-1:0]           q;
    logic [SB-1:0]           r;
    t = a + ROUND_HALF;
    q = t[ACC_W-1:FRAC_BITS];
    if (&q[QW-1:SB-1] || ~|q[QW-1:SB-1]) begin
      r = q[SB-1:0];
    end else if (q[QW-1]) begin
      r = SMIN;
    end else begin
      r = SMAX;
    end
    return r;
  endfunction

  function automatic logic signed [SB-1:0] sat_add(input logic signed [SB-1:0] a,
                                                   input logic signed [SB-1:0] b);
    logic [SB:0]   s;
    logic [SB-1:0] r;
    s = {a[SB-1], a} + {b[SB-1], b};
    if (s[SB] != s[SB-1]) begin
      r = s[SB] ? SMIN : SMAX;
    end else begin
      r = s[SB-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [OPND_W-1:0] gain_op(input logic [GAIN_W-1:0] g);
    return {{(OPND_W - GAIN_W){1'b0}}, g};
  endfunction

  function automatic logic signed [OPND_W-1:0] coef_op(input logic signed [COEF_W-1:0] c);
    return {{(OPND_W - COEF_W){c[COEF_W-1]}}, c};
  endfunction

  logic signed [SB-1:0]     in_l_q, in_r_q;
  logic signed [SB-1:0]     tap_l, tap_r, wsrc_l, wsrc_r;
  logic signed [OPND_W-1:0] op_a;
  logic signed [SB-1:0]     op_b;
  logic signed [PW-1:0]     prod_d, prod_q;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_l_q, acc_r_q;
  logic signed [SB-1:0]     mix_l_q, mix_r_q;
  logic signed [SB-1:0]     y_l_q, y_r_q;
  logic signed [SB-1:0]     w_l_q, w_r_q;
  logic signed [SB-1:0]     x1_l_q, x2_l_q, y1_l_q, y2_l_q;
  logic signed [SB-1:0]     x1_r_q, x2_r_q, y1_r_q, y2_r_q;

  // Entries never written since reset read as zero.
  assign tap_l = tap_ok_i ? tap_raw_i[SB-1:0]      : '0;
  assign tap_r = tap_ok_i ? tap_raw_i[2*SB-1:SB]   : '0;
  // With a zero delay the output tap is the sample just written.
  assign wsrc_l = tap_eq_i ? y_l_q : tap_l;
  assign wsrc_r = tap_eq_i ? y_r_q : tap_r;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      in_l_q <= left_in_i;
      in_r_q <= right_in_i;
    end
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (ctl_i.step)
      STEP_PRE_L: begin op_a = gain_op(cfg_i.pre_gain);      op_b = in_l_q;  end
      STEP_PRE_R: begin op_a = gain_op(cfg_i.pre_gain);      op_b = in_r_q;  end
      STEP_FB_L:  begin op_a = gain_op(cfg_i.feedback_gain); op_b = tap_l;   end
      STEP_FB_R:  begin op_a = gain_op(cfg_i.feedback_gain); op_b = tap_r;   end
      STEP_X1_L:  begin op_a = coef_op(cfg_i.coef_x1);       op_b = x1_l_q;  end
      STEP_X1_R:  begin op_a = coef_op(cfg_i.coef_x1);       op_b = x1_r_q;  end
      STEP_X2_L:  begin op_a = coef_op(cfg_i.coef_x0_x2);    op_b = x2_l_q;  end
      STEP_X2_R:  begin op_a = coef_op(cfg_i.coef_x0_x2);    op_b = x2_r_q;  end
      STEP_Y1_L:  begin op_a = coef_op(cfg_i.coef_y1);       op_b = y1_l_q;  end
      STEP_Y1_R:  begin op_a = coef_op(cfg_i.coef_y1);       op_b = y1_r_q;  end
      STEP_Y2_L:  begin op_a = coef_op(cfg_i.coef_y2);       op_b = y2_l_q;  end
      STEP_Y2_R:  begin op_a = coef_op(cfg_i.coef_y2);       op_b = y2_r_q;  end
      STEP_MIX_L: begin op_a = coef_op(cfg_i.coef_x0_x2);    op_b = mix_l_q; end
      STEP_MIX_R: begin op_a = coef_op(cfg_i.coef_x0_x2);    op_b = mix_r_q; end
      STEP_WET_L: begin op_a = gain_op(cfg_i.wet_gain);      op_b = wsrc_l;  end
      STEP_WET_R: begin op_a = gain_op(cfg_i.wet_gain);      op_b = wsrc_r;  end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_d   = op_a * op_b;
  assign prod_ext = {prod_q[PW-1], prod_q};

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.run) begin
      case (ctl_i.step) inside
        STEP_PRE_R, STEP_X1_R, STEP_WET_R:                   acc_l_q <= prod_ext;
        STEP_FB_R, STEP_X2_R, STEP_Y1_R, STEP_Y2_R, STEP_MIX_R:
          acc_l_q <= acc_l_q + prod_ext;
        default: ;
      endcase
      case (ctl_i.step) inside
        STEP_FB_L, STEP_X2_L, STEP_ROUND_L:                  acc_r_q <= prod_ext;
        STEP_X1_L, STEP_Y1_L, STEP_Y2_L, STEP_MIX_L, STEP_ACC_R:
          acc_r_q <= acc_r_q + prod_ext;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.run) begin
      case (ctl_i.step)
        STEP_X1_R:    mix_l_q <= round_sat(acc_l_q);
        STEP_X2_L:    mix_r_q <= round_sat(acc_r_q);
        STEP_ACC_R:   y_l_q   <= round_sat(acc_l_q);
        STEP_WET_L:   y_r_q   <= round_sat(acc_r_q);
        STEP_ROUND_L: w_l_q   <= round_sat(acc_l_q);
        STEP_ROUND_R: w_r_q   <= round_sat(acc_r_q);
        default: ;
      endcase
    end
  end

  // Filter histories move on once both channels have used them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_l_q <= '0;
      x2_l_q <= '0;
      y1_l_q <= '0;
      y2_l_q <= '0;
      x1_r_q <= '0;
      x2_r_q <= '0;
      y1_r_q <= '0;
      y2_r_q <= '0;
    end else if (ctl_i.run && ctl_i.step == STEP_WET_R) begin
      x2_l_q <= x1_l_q;
      x1_l_q <= mix_l_q;
      y2_l_q <= y1_l_q;
      y1_l_q <= y_l_q;
      x2_r_q <= x1_r_q;
      x1_r_q <= mix_r_q;
      y2_r_q <= y1_r_q;
      y1_r_q <= y_r_q;
    end
  end

  assign wr_data_o   = {y_r_q, y_l_q};
  assign left_out_o  = sat_add(in_l_q, w_l_q);
  assign right_out_o = sat_add(in_r_q, w_r_q);

endmodule

`default_nettype wire

### hw/rtl/stereo_feedback_delay_lowpass.sv
// Frames are taken one at a time: each runs the schedule from STEP_PRE_L
// to STEP_OUT; its result beat is shown from the output register. A single
// shared multiplier runs the sixteen products of a frame, with rounding
// steps in between. A write to delay_length occupies the modulo unit,
// during which no frame is taken. Reset is asynchronous; the ring is not
// swept: a write pointer and wrap flag make unwritten entries read as zero.
`default_nettype none

module stereo_feedback_delay_lowpass #(
  parameter int RING_DEPTH  = sfdl_pkg::DEF_RING_DEPTH,
  parameter int SAMPLE_BITS = sfdl_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [SAMPLE_BITS-1:0] right_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfdl_pkg::APB_AW-1:0]   paddr,
  input  logic [sfdl_pkg::APB_DW-1:0]   pwdata,
  output logic [sfdl_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import sfdl_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(RING_DEPTH);
  localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(RING_DEPTH);
  localparam logic [AW-1:0] LAST_IDX  = AW'(RING_DEPTH - 1);

  cfg_t            cfg;
  logic [AW-1:0]   dmod;
  logic            mod_busy;

  state_e          state_q, state_d;
  step_e           step_q, step_d;
  logic            accept;
  logic            out_load;
  mac_ctl_t        ctl;

  logic [AW-1:0]   ptr_q, wi_new;
  logic            full_q;
  logic [AW:0]     tsum, tap_sel;
  logic [AW-1:0]   tap_d, tap_q, wi_q;
  logic            tap_ok_d, tap_ok_q, tap_eq_q;

  logic [2*SB-1:0] rd_data, wr_data;
  logic signed [SB-1:0] mac_left, mac_right;
  logic            out_valid_q;
  logic signed [SB-1:0] left_out_q, right_out_q;

  sfdl_regs #(
    .RING_DEPTH(RING_DEPTH)
  ) u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel_i   (psel),
    .penable_i(penable),
    .pwrite_i (pwrite),
    .paddr_i  (paddr),
    .pwdata_i (pwdata),
    .prdata_o (prdata),
    .pready_o (pready),
    .cfg_o    (cfg),
    .dmod_o   (dmod),
    .busy_o   (mod_busy)
  );

  // Pointer and tap for the next frame; the pointer wraps from the last
  // entry to zero.
  assign wi_new  = (ptr_q == LAST_IDX) ? '0 : ptr_q + AW'(1);
  assign tsum    = {1'b0, wi_new} + DEPTH_EXT - {1'b0, dmod};
  assign tap_sel = (tsum >= DEPTH_EXT) ? tsum - DEPTH_EXT : tsum;
  assign tap_d   = tap_sel[AW-1:0];
  // Before the first wrap only entries 1 up to the last written hold data.
  assign tap_ok_d = full_q || (tap_d != '0 && tap_d <= ptr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_PRE_L;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    out_load   = 1'b0;
    in_stall_o = 1'b1;
    accept     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = mod_busy;
        accept     = in_valid_i && !mod_busy;
        if (accept) begin
          state_d = ST_RUN;
          step_d  = STEP_PRE_L;
        end
      end
      ST_RUN: begin
        if (step_q == STEP_OUT) begin
          if (!out_valid_q || !out_stall_i) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
          end
        end else begin
          step_d = step_e'(step_q + 5'd1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      full_q <= 1'b0;
    end else if (accept) begin
      ptr_q  <= wi_new;
      full_q <= full_q || (wi_new == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tap_q    <= tap_d;
      wi_q     <= wi_new;
      tap_ok_q <= tap_ok_d;
      tap_eq_q <= (dmod == '0);
    end
  end

  assign ctl.load = accept;
  assign ctl.run  = (state_q == ST_RUN);
  assign ctl.step = step_q;

  sfdl_ring_ram #(
    .DEPTH(RING_DEPTH),
    .WIDTH(2 * SB)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ctl.run && step_q == STEP_WET_R),
    .waddr_i(wi_q),
    .wdata_i(wr_data),
    .re_i   (ctl.run && step_q == STEP_PRE_L),
    .raddr_i(tap_q),
    .rdata_o(rd_data)
  );

  sfdl_mac #(
    .SAMPLE_BITS(SB)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .cfg_i      (cfg),
    .left_in_i  (left_in_i),
    .right_in_i (right_in_i),
    .tap_raw_i  (rd_data),
    .tap_ok_i   (tap_ok_q),
    .tap_eq_i   (tap_eq_q),
    .wr_data_o  (wr_data),
    .left_out_o (mac_left),
    .right_out_o(mac_right)
  );

  // Output register: the next frame can be taken while a result beat waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      left_out_q  <= mac_left;
      right_out_q <= mac_right;
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;

endmodule

`default_nettype wire

### hw/rtl/sfdl_checker.sv
`default_nettype none

module sfdl_checker #(
  parameter int SAMPLE_BITS = sfdl_pkg::DEF_SAMPLE_BITS
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [SAMPLE_BITS-1:0] left_out_o,
  input logic signed [SAMPLE_BITS-1:0] right_out_o
);

  // A result beat held back by the sink stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(left_out_o) && $stable(right_out_o))
    else $error("stalled result beat changed");

  // Frames are worked one at a time: a taken beat closes the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second frame taken while one is in progress");

  // A new result only appears at the end of a frame's work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result beat appeared with no frame in progress");

endmodule

bind stereo_feedback_delay_lowpass sfdl_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_sfdl_checker (.*);

`default_nettype wire
